### hdl/cwat_pkg.sv
// Package for the cue window action trigger: sizes, request and state codes,
// and the packed types for command beats, result beats and the cell chain.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package cwat_pkg;

  localparam int CueCount    = 64;
  localparam int ActionCount = 10;

  localparam int CueAddrW = (CueCount > 1) ? $clog2(CueCount) : 1;
  localparam int CueIdxW  = 6;
  localparam int PosW     = 16;
  localparam int ActIdxW  = 4;
  localparam int ValW     = 7;
  localparam int LevelW   = 8;
  localparam int MaskW    = 16;
  localparam int AddrW    = 3;

  // Action level after reset: minus one, i.e. never set.
  localparam logic [LevelW-1:0] LevelNone = '1;

  // Register index as decoded from the word address bit of paddr.
  localparam logic RegOnceMask = 1'b0;

  typedef enum logic [1:0] {
    ReqLoad  = 2'd0,
    ReqTick  = 2'd1,
    ReqClear = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    StIdle  = 3'b001,
    StWalk  = 3'b010,
    StDrain = 3'b100
  } state_e;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [CueIdxW-1:0] cue_index;
    logic [PosW-1:0]    cue_start;
    logic [PosW-1:0]    cue_end;
    logic [ActIdxW-1:0] cue_action;
    logic [ValW-1:0]    cue_value;
    logic [PosW-1:0]    position;
  } cmd_t;

  typedef struct packed {
    logic [ActIdxW-1:0]       action_index;
    logic                     action_active;
    logic signed [LevelW-1:0] action_value;
    logic                     last;
  } res_t;

  // One stored cue window.
  typedef struct packed {
    logic [PosW-1:0]    start;
    logic [PosW-1:0]    stop;
    logic [ActIdxW-1:0] action;
    logic [ValW-1:0]    value;
  } cue_rec_t;

  // Action event travelling down the cell chain: set (with value) or release.
  typedef struct packed {
    logic               vld;
    logic               set;
    logic [ActIdxW-1:0] action;
    logic [ValW-1:0]    value;
  } cue_ev_t;

  // Report of one cell while the report token sits at its input.
  typedef struct packed {
    logic              vld;
    logic              active;
    logic [LevelW-1:0] level;
  } rep_t;

endpackage

### hdl/cwat_cue_walk.sv
// Cue table memory, per-cue used marks and the window decision for a tick.
// Feeds action events and the report token into the head of the cell chain.
// Depends on cwat_pkg.
`timescale 1ns / 1ps

module cwat_cue_walk (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [cwat_pkg::CueAddrW-1:0]  wr_addr_i,
  input  cwat_pkg::cue_rec_t             wr_rec_i,
  input  logic                           rd_en_i,
  input  logic [cwat_pkg::CueAddrW-1:0]  rd_addr_i,
  input  logic                           tok_i,
  input  logic [cwat_pkg::PosW-1:0]      pos_i,
  input  logic [cwat_pkg::MaskW-1:0]     once_mask_i,
  input  logic                           clear_i,
  output cwat_pkg::cue_ev_t              ev_o,
  output logic                           tok_o
);

  cwat_pkg::cue_rec_t mem_q [cwat_pkg::CueCount];
  cwat_pkg::cue_rec_t rd_rec_q;
  logic [cwat_pkg::CueAddrW-1:0] rd_idx_q;
  logic rd_vld_q;
  logic rd_tok_q;

  logic [cwat_pkg::CueCount-1:0] used_q, used_d;
  cwat_pkg::cue_ev_t ev_q, ev_d;
  logic tok_q;

  logic in_win;
  logic blocked;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_rec_i;
    end
    if (rd_en_i) begin
      rd_rec_q <= mem_q[rd_addr_i];
      rd_idx_q <= rd_addr_i;
    end
  end

  // Open window test and release test for the cue just read.
  always_comb begin
    used_d  = used_q;
    ev_d    = '0;
    in_win  = (rd_rec_q.start < pos_i) && (pos_i < rd_rec_q.stop);
    blocked = once_mask_i[rd_rec_q.action] && used_q[rd_idx_q];
    if (clear_i) begin
      used_d = '0;
    end else if (rd_vld_q) begin
      ev_d.action = rd_rec_q.action;
      ev_d.value  = rd_rec_q.value;
      if (in_win) begin
        if (!blocked) begin
          ev_d.vld          = 1'b1;
          ev_d.set          = 1'b1;
          used_d[rd_idx_q]  = 1'b1;
        end
      end else if (used_q[rd_idx_q] && (pos_i >= rd_rec_q.stop)) begin
        ev_d.vld         = 1'b1;
        ev_d.set         = 1'b0;
        used_d[rd_idx_q] = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
      rd_tok_q <= 1'b0;
      used_q   <= '0;
      ev_q     <= '0;
      tok_q    <= 1'b0;
    end else begin
      rd_vld_q <= rd_en_i;
      rd_tok_q <= tok_i;
      used_q   <= used_d;
      ev_q     <= ev_d;
      tok_q    <= rd_tok_q;
    end
  end

  assign ev_o  = ev_q;
  assign tok_o = tok_q;

endmodule

### hdl/cwat_action_cell.sv
// One action cell: holds the active flag and level of one action, applies
// events meant for it and passes events and the report token on.
// Depends on cwat_pkg.
`timescale 1ns / 1ps

module cwat_action_cell (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cwat_pkg::ActIdxW-1:0]  idx_i,
  input  logic                          once_i,
  input  logic                          clear_i,
  input  cwat_pkg::cue_ev_t             ev_i,
  input  logic                          tok_i,
  output cwat_pkg::cue_ev_t             ev_o,
  output logic                          tok_o,
  output cwat_pkg::rep_t                rep_o
);

  logic on_q, on_d;
  logic [cwat_pkg::LevelW-1:0] level_q, level_d;
  cwat_pkg::cue_ev_t ev_q;
  logic tok_q;
  logic hit;

  assign hit = ev_i.vld && (ev_i.action == idx_i);

  always_comb begin
    on_d    = on_q;
    level_d = level_q;
    priority if (clear_i) begin
      on_d = 1'b0;
    end else if (hit) begin
      on_d = ev_i.set;
      if (ev_i.set) begin
        level_d = {1'b0, ev_i.value};
      end
    end else if (tok_i && once_i) begin
      // Reporting a once-only action clears it.
      on_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q    <= 1'b0;
      level_q <= cwat_pkg::LevelNone;
      ev_q    <= '0;
      tok_q   <= 1'b0;
    end else begin
      on_q    <= on_d;
      level_q <= level_d;
      ev_q    <= ev_i;
      tok_q   <= tok_i;
    end
  end

  assign rep_o.vld    = tok_i;
  assign rep_o.active = on_q;
  assign rep_o.level  = level_q;
  assign ev_o         = ev_q;
  assign tok_o        = tok_q;

endmodule

### hdl/cue_window_action_trigger.sv
// Cue window action trigger: load and clear beats leave the block idle; a tick beat
// gives one report per action, one report per cycle, in order of action index.
// A tick keeps the block busy through the one-cue-a-cycle read of the cue memory
// and the walk of the report token down the action cells.
// Reset is asynchronous and active low; cue memory contents are undefined until loaded.
// Reports cannot be stalled by the receiver; each is shown for exactly one cycle.
`timescale 1ns / 1ps

module cue_window_action_trigger (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Command beats.
  input  logic                           start,
  output logic                           busy,
  input  cwat_pkg::cmd_t                 cmd_i,
  // Report beats.
  output logic                           out_valid_o,
  output cwat_pkg::res_t                 result_o,
  // Register port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cwat_pkg::AddrW-1:0]     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  // The design is a short sequencer feeding a row of identical action cells.
  // The sequencer reads the cue memory one entry a cycle; the walk unit decides,
  // per cue, whether it fires or releases, and sends an event into the first cell.
  // Events shift one cell per cycle, so every cell sees them in cue order. In the
  // cycle after the last event a report token enters the row; as it passes a
  // cell, that cell's state is captured into the output register and, for a
  // once-only action, the active flag is cleared.

  cwat_pkg::state_e state_q, state_d;
  logic [cwat_pkg::CueAddrW-1:0] cnt_q, cnt_d;
  logic [cwat_pkg::PosW-1:0] pos_q;
  logic tok_pend_q, tok_pend_d;
  logic [cwat_pkg::MaskW-1:0] once_mask_q;

  logic accept;
  logic do_load;
  logic do_clear;
  logic do_tick;
  logic walking;
  logic cnt_last;
  logic cfg_wr;

  cwat_pkg::cue_rec_t wr_rec;

  // Chain links: element k is the input of cell k, element ActionCount its output.
  cwat_pkg::cue_ev_t ev_chain [cwat_pkg::ActionCount+1];
  logic [cwat_pkg::ActionCount:0] tok_chain;
  cwat_pkg::rep_t rep [cwat_pkg::ActionCount];

  logic rep_vld;
  logic rep_act;
  logic [cwat_pkg::LevelW-1:0] rep_lvl;
  logic [cwat_pkg::ActIdxW-1:0] rep_idx;
  logic rep_last;

  logic out_valid_q;
  cwat_pkg::res_t result_q;

  assign accept   = start && !busy;
  assign do_load  = accept && (cmd_i.req_type == cwat_pkg::ReqLoad)
                    && ({1'b0, cmd_i.cue_index} < (cwat_pkg::CueIdxW+1)'(cwat_pkg::CueCount));
  assign do_clear = accept && (cmd_i.req_type == cwat_pkg::ReqClear);
  assign do_tick  = accept && (cmd_i.req_type == cwat_pkg::ReqTick);
  assign walking  = (state_q == cwat_pkg::StWalk);
  assign cnt_last = (cnt_q == cwat_pkg::CueAddrW'(cwat_pkg::CueCount - 1));

  assign wr_rec.start  = cmd_i.cue_start;
  assign wr_rec.stop   = cmd_i.cue_end;
  assign wr_rec.action = cmd_i.cue_action;
  assign wr_rec.value  = cmd_i.cue_value;

  // Sequencer: idle, walk over every cue, then wait for the last report.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    tok_pend_d = 1'b0;
    unique case (state_q)
      cwat_pkg::StIdle: begin
        if (do_tick) begin
          state_d = cwat_pkg::StWalk;
          cnt_d   = '0;
        end
      end
      cwat_pkg::StWalk: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_last) begin
          state_d    = cwat_pkg::StDrain;
          tok_pend_d = 1'b1;
        end
      end
      cwat_pkg::StDrain: begin
        if (rep_vld && rep_last) begin
          state_d = cwat_pkg::StIdle;
        end
      end
      default: begin
        state_d = cwat_pkg::StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= cwat_pkg::StIdle;
      cnt_q      <= '0;
      tok_pend_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      cnt_q      <= cnt_d;
      tok_pend_q <= tok_pend_d;
    end
  end

  // The position of a tick is held for the whole walk.
  always_ff @(posedge clk_i) begin
    if (do_tick) begin
      pos_q <= cmd_i.position;
    end
  end

  assign busy = (state_q != cwat_pkg::StIdle);

  // Register port: a single register, the once-only mask, at byte addresses 0 to 3 (paddr[2] clear).
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == cwat_pkg::RegOnceMask);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      once_mask_q <= cwat_pkg::MaskW'(623);
    end else if (cfg_wr) begin
      once_mask_q <= pwdata[cwat_pkg::MaskW-1:0];
    end
  end

  assign prdata = (paddr[2] == cwat_pkg::RegOnceMask)
                  ? {{(32-cwat_pkg::MaskW){1'b0}}, once_mask_q} : '0;

  cwat_cue_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_en_i     (do_load),
    .wr_addr_i   (cmd_i.cue_index[cwat_pkg::CueAddrW-1:0]),
    .wr_rec_i    (wr_rec),
    .rd_en_i     (walking),
    .rd_addr_i   (cnt_q),
    .tok_i       (tok_pend_q),
    .pos_i       (pos_q),
    .once_mask_i (once_mask_q),
    .clear_i     (do_clear),
    .ev_o        (ev_chain[0]),
    .tok_o       (tok_chain[0])
  );

  for (genvar k = 0; k < cwat_pkg::ActionCount; k++) begin : g_cell
    cwat_action_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (cwat_pkg::ActIdxW'(k)),
      .once_i  (once_mask_q[k]),
      .clear_i (do_clear),
      .ev_i    (ev_chain[k]),
      .tok_i   (tok_chain[k]),
      .ev_o    (ev_chain[k+1]),
      .tok_o   (tok_chain[k+1]),
      .rep_o   (rep[k])
    );
  end

  // Only one cell holds the token at a time, so the reports are simply ORed.
  always_comb begin
    rep_vld = 1'b0;
    rep_act = 1'b0;
    rep_lvl = '0;
    rep_idx = '0;
    for (int k = 0; k < cwat_pkg::ActionCount; k++) begin
      if (rep[k].vld) begin
        rep_vld = 1'b1;
        rep_act = rep_act | rep[k].active;
        rep_lvl = rep_lvl | rep[k].level;
        rep_idx = rep_idx | cwat_pkg::ActIdxW'(k);
      end
    end
  end

  assign rep_last = (rep_idx == cwat_pkg::ActIdxW'(cwat_pkg::ActionCount - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= rep_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rep_vld) begin
      result_q.action_index  <= rep_idx;
      result_q.action_active <= rep_act;
      result_q.action_value  <= $signed(rep_lvl);
      result_q.last          <= rep_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

  // The reports of one tick come in an unbroken run of beats.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !result_o.last |=> out_valid_o)
    else $error("report run broken before the final beat");

  // The final report of a tick leaves the block ready for the next command.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_o.last |-> !busy)
    else $error("still busy when the final report is shown");

  // An accepted tick always makes the block busy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (cmd_i.req_type == cwat_pkg::ReqTick) |=> busy)
    else $error("tick accepted without the walk starting");

  // At most one report token travels down the cell row.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_chain))
    else $error("more than one report token in the cell row");

endmodule
